// ===== sv/prc_pkg.sv =====
// Shared types, fixed-point constants and CORDIC tables for polar_to_cartesian.
package prc_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 30;
	localparam int ANG_W      = 32;
	localparam int MAX_STEPS  = 24;
	localparam int GAIN_W     = 31;
	// sign, radius after negation, gain fraction and CORDIC growth headroom
	localparam int ACC_W      = DATA_WIDTH + 1 + GAIN_W + 1;
	localparam int RND_W      = ACC_W - FRAC_BITS;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] radius;
		logic signed [DATA_WIDTH-1:0] angle;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] x_coord;
		logic signed [DATA_WIDTH-1:0] y_coord;
	} res_t;

	// atan(2^-i), 2^32 units per full turn
	localparam logic [ANG_W-1:0] ATAN_TAB [0:MAX_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// gain compensation after n steps, Q1.30, entry n-1
	localparam logic [GAIN_W-1:0] GAIN_TAB [0:MAX_STEPS-1] = '{
		31'd759250125, 31'd679093956, 31'd658817909, 31'd653730438,
		31'd652457343, 31'd652138998, 31'd652059405, 31'd652039507,
		31'd652034532, 31'd652033289, 31'd652032978, 31'd652032900,
		31'd652032881, 31'd652032876, 31'd652032874, 31'd652032874,
		31'd652032874, 31'd652032874, 31'd652032874, 31'd652032874,
		31'd652032874, 31'd652032874, 31'd652032874, 31'd652032874
	};

endpackage

// ===== sv/polar_to_cartesian.sv =====
// Pipelined rotation-mode CORDIC converting a polar request to rectangular coordinates.
// One request is taken every clock cycle (busy stays low); each result appears on res with
// done high for one cycle, once it has passed through every stage of the pipeline: one
// stage for the half-plane pre-rotation and gain multiply, one stage per micro-rotation,
// and one stage for rounding and saturation. The receiver cannot stall, so results must
// be captured in the cycle that done is high. Results that round past the positive or
// negative limit saturate (for example radius -32768 at angle -32768 gives 32767).
module polar_to_cartesian
	import prc_pkg::*;
#(
	parameter int ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);

	localparam int N   = (ITERATIONS > MAX_STEPS) ? MAX_STEPS :
	                     (ITERATIONS < 1) ? 1 : ITERATIONS;
	localparam int LAT = N + 2;
	localparam logic [GAIN_W-1:0] GAIN = GAIN_TAB[N-1];
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((2 ** (DATA_WIDTH - 1)) - 1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

	function automatic logic signed [DATA_WIDTH-1:0] round_sat(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0] sum;
		logic signed [RND_W-1:0] rnd;
		sum = v + (ACC_W'(1) <<< (FRAC_BITS - 1));
		rnd = RND_W'(sum >>> FRAC_BITS);
		if (rnd > SAT_HI) begin
			return SAT_HI[DATA_WIDTH-1:0];
		end else if (rnd < SAT_LO) begin
			return SAT_LO[DATA_WIDTH-1:0];
		end
		return rnd[DATA_WIDTH-1:0];
	endfunction

	logic accept;
	logic [ANG_W-1:0] ang_in;
	logic flip;
	logic signed [DATA_WIDTH:0] rad_ext;
	logic signed [DATA_WIDTH:0] rad_pre;
	logic signed [ACC_W-1:0] prod;

	logic v_s [0:N];
	logic signed [ACC_W-1:0] x_s [0:N];
	logic signed [ACC_W-1:0] y_s [0:N];
	logic signed [ANG_W-1:0] z_s [0:N];

	logic done_q;
	res_t res_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Fold angles outside the centre half-plane: negate radius, add pi.
	always_comb begin
		ang_in  = {cmd.angle, {(ANG_W - DATA_WIDTH){1'b0}}};
		flip    = ang_in[ANG_W-1] ^ ang_in[ANG_W-2];
		rad_ext = {cmd.radius[DATA_WIDTH-1], cmd.radius};
		rad_pre = flip ? -rad_ext : rad_ext;
		prod    = ACC_W'(rad_pre) * ACC_W'($signed({1'b0, GAIN}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s[0] <= prod;
			y_s[0] <= '0;
			z_s[0] <= {ang_in[ANG_W-1] ^ flip, ang_in[ANG_W-2:0]};
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic pos;
		logic signed [ACC_W-1:0] dx;
		logic signed [ACC_W-1:0] dy;
		logic signed [ANG_W-1:0] da;

		assign pos = !z_s[i][ANG_W-1];
		assign dx  = y_s[i] >>> i;
		assign dy  = x_s[i] >>> i;
		assign da  = $signed(ATAN_TAB[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (v_s[i]) begin
				x_s[i+1] <= pos ? x_s[i] - dx : x_s[i] + dx;
				y_s[i+1] <= pos ? y_s[i] + dy : y_s[i] - dy;
				z_s[i+1] <= pos ? z_s[i] - da : z_s[i] + da;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s[N]) begin
			res_q.x_coord <= round_sat(x_s[N]);
			res_q.y_coord <= round_sat(y_s[N]);
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// Every request yields a result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request did not produce a result after the pipeline latency");

	// No result without a request the latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a matching request");

	// Pre-rotation leaves the angle in the centre half-plane.
	a_half_plane: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> (z_s[0][ANG_W-1] == z_s[0][ANG_W-2]))
		else $error("pre-rotated angle outside minus pi/2 to pi/2");

endmodule
